>>> hdl/gffns_pkg.sv
package gffns_pkg;

   localparam int GRID_DIM_DEF    = 32;
   localparam int QUEUE_DEPTH_DEF = 1024;
   localparam int COORD_W         = 5;
   localparam int CODE_W          = 3;
   localparam int DIR_W           = 3;

   localparam logic [CODE_W-1:0] CODE_WALL = 3'd0;
   localparam logic [CODE_W-1:0] CODE_VENT = 3'd2;

   localparam logic [DIR_W-1:0] DIR_UP      = 3'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_NO_PATH = 3'd4;
   localparam logic [DIR_W-1:0] DIR_ARRIVED = 3'd5;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,     // sweep map and marks after reset
      ST_IDLE,
      ST_VCLR,      // clear visited marks for a query
      ST_START,     // read start cell
      ST_START_CHK,
      ST_POP,       // read queue head
      ST_POP_WAIT,
      ST_NB_RD,     // read neighbour cell and mark
      ST_NB_CHK,
      ST_RESULT
   } state_type;

endpackage

>>> hdl/gffns_if.sv
interface gffns_req_if;
   import gffns_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic [CODE_W-1:0]  cell_value;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] dest_x;
   logic [COORD_W-1:0] dest_y;
   logic               allow_vent;
   modport source (output valid, func, cell_x, cell_y, cell_value, start_x, start_y,
                   dest_x, dest_y, allow_vent, input ready);
   modport sink (input valid, func, cell_x, cell_y, cell_value, start_x, start_y,
                 dest_x, dest_y, allow_vent, output ready);
endinterface

interface gffns_rsp_if;
   import gffns_pkg::*;
   logic             valid;
   logic             ready;
   logic [DIR_W-1:0] direction;
   modport source (output valid, direction, input ready);
   modport sink (input valid, direction, output ready);
endinterface

>>> hdl/grid_flood_fill_next_step_core.sv
// Channel | Dir | Port     | Word
// req     | in  | req_port | func, cell fields, start, dest, allow_vent
// rsp     | out | rsp_port | direction (one per query, none per write)
//
// A write updates an in-range map cell when accepted. A query with start equal to dest answers
// at once; any other clears the marks, checks the start, then takes each dequeued cell and tries
// its neighbours in turn. The single map/mark read port and the sequencer set this pace.
// After reset a clearing pass over all GRID_DIM*GRID_DIM cells runs before the first word is
// taken. The result sits in an output register; the block waits there until rsp is taken.
module grid_flood_fill_next_step_core
   import gffns_pkg::*;
#(
   parameter int GRID_DIM    = GRID_DIM_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   gffns_req_if.sink  req_port,
   gffns_rsp_if.source rsp_port
);
   localparam int CELLS = GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_DIM);
   localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int QW    = 2 * CW;
   localparam int NW    = (CW + 2 > COORD_W + 1) ? CW + 2 : COORD_W + 1;

   logic [CODE_W-1:0] map_mem [CELLS];
   logic              mark_mem [CELLS];
   logic [QW-1:0]     queue_mem [QUEUE_DEPTH];

   state_type state_ff, state_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic [QCW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic               vent_ff, vent_in;
   logic [CW:0]        cx_ff, cx_in, cy_ff, cy_in;   // current cell, one extra bit
   logic [1:0]         dir_ff, dir_in;
   logic [DIR_W-1:0]   res_ff, res_in;

   // memory port controls
   logic              map_we, mark_we, mark_wd, q_we;
   logic [AW-1:0]     map_wa, mark_wa, rd_a;
   logic [QAW-1:0]    q_wa;
   logic [CODE_W-1:0] map_wd;
   logic [QW-1:0]     q_wd;
   logic [CODE_W-1:0] map_rd_ff;
   logic              mark_rd_ff;
   logic [QW-1:0]     q_rd_ff;

   // neighbour position, wide enough that -1 and any destination never collide
   logic [NW-1:0] nx, ny;
   logic          nb_on, nb_dest, nb_pass;
   logic [AW-1:0] nb_idx;

   always_comb begin
      nx = NW'(cx_ff);
      ny = NW'(cy_ff);
      case (dir_ff)
         2'd0:    ny = NW'(cy_ff) - 1'b1;
         2'd1:    nx = NW'(cx_ff) + 1'b1;
         2'd2:    ny = NW'(cy_ff) + 1'b1;
         default: nx = NW'(cx_ff) - 1'b1;
      endcase
      nb_on   = (nx < NW'(GRID_DIM)) && (ny < NW'(GRID_DIM));
      nb_dest = (nx == NW'(dx_ff)) && (ny == NW'(dy_ff));
      nb_idx  = AW'(ny[CW-1:0]) * AW'(GRID_DIM) + AW'(nx[CW-1:0]);
   end

   logic start_on;
   logic [AW-1:0] start_idx;
   assign start_on  = (32'(sx_ff) < GRID_DIM) && (32'(sy_ff) < GRID_DIM);
   assign start_idx = AW'(32'(sy_ff) * GRID_DIM + 32'(sx_ff));
   assign nb_pass = (map_rd_ff != CODE_WALL) && !(map_rd_ff == CODE_VENT && !vent_ff);

   logic accept;
   assign accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign rsp_port.valid = (state_ff == ST_RESULT);
   assign rsp_port.direction = res_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (cnt_ff == (AW+1)'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept && req_port.func == FUNC_QUERY) begin
               if (req_port.start_x == req_port.dest_x && req_port.start_y == req_port.dest_y)
                  state_in = ST_RESULT;
               else
                  state_in = ST_VCLR;
            end
         end
         ST_VCLR:      if (cnt_ff == (AW+1)'(CELLS - 1)) state_in = ST_START;
         ST_START:     state_in = ST_START_CHK;
         ST_START_CHK: state_in = (start_on && nb_pass && QUEUE_DEPTH > 0) ? ST_POP : ST_RESULT;
         ST_POP:       state_in = (head_ff < tail_ff) ? ST_POP_WAIT : ST_RESULT;
         ST_POP_WAIT:  state_in = ST_NB_RD;
         ST_NB_RD:     state_in = nb_dest ? ST_RESULT : ST_NB_CHK;
         ST_NB_CHK:    state_in = (dir_ff == 2'd3) ? ST_POP : ST_NB_RD;
         ST_RESULT:    if (rsp_port.ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff; head_in = head_ff; tail_in = tail_ff;
      sx_in = sx_ff; sy_in = sy_ff; dx_in = dx_ff; dy_in = dy_ff; vent_in = vent_ff;
      cx_in = cx_ff; cy_in = cy_ff; dir_in = dir_ff; res_in = res_ff;
      map_we = 1'b0; map_wa = '0; map_wd = '0;
      mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0;
      q_we = 1'b0; q_wa = '0; q_wd = '0;
      rd_a = nb_idx;
      case (state_ff)
         ST_CLEAR: begin
            map_we = 1'b1; map_wa = cnt_ff[AW-1:0];
            mark_we = 1'b1; mark_wa = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               sx_in = req_port.start_x; sy_in = req_port.start_y;
               dx_in = req_port.dest_x; dy_in = req_port.dest_y;
               vent_in = req_port.allow_vent;
               res_in = DIR_ARRIVED;
               if (req_port.func == FUNC_WRITE && 32'(req_port.cell_x) < GRID_DIM
                   && 32'(req_port.cell_y) < GRID_DIM) begin
                  map_we = 1'b1;
                  map_wa = AW'(32'(req_port.cell_y) * GRID_DIM + 32'(req_port.cell_x));
                  map_wd = req_port.cell_value;
               end
            end
         end
         ST_VCLR: begin
            mark_we = 1'b1; mark_wa = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
            head_in = '0; tail_in = '0;
         end
         ST_START: rd_a = start_idx;
         ST_START_CHK: begin
            res_in = DIR_NO_PATH;
            if (start_on && nb_pass && QUEUE_DEPTH > 0) begin
               mark_we = 1'b1; mark_wa = start_idx; mark_wd = 1'b1;
               q_we = 1'b1; q_wa = '0; q_wd = {CW'(sy_ff), CW'(sx_ff)};
               tail_in = QCW'(1);
            end
         end
         ST_POP: dir_in = 2'd0;
         ST_POP_WAIT: begin
            // queue entries hold {row, column}
            cx_in = {1'b0, q_rd_ff[CW-1:0]};
            cy_in = {1'b0, q_rd_ff[QW-1:CW]};
            head_in = head_ff + 1'b1;
         end
         ST_NB_RD: begin
            if (nb_dest) res_in = {1'b0, dir_ff};
         end
         ST_NB_CHK: begin
            if (nb_on && nb_pass && !mark_rd_ff && tail_ff < QCW'(QUEUE_DEPTH)) begin
               mark_we = 1'b1; mark_wa = nb_idx; mark_wd = 1'b1;
               q_we = 1'b1; q_wa = tail_ff[QAW-1:0]; q_wd = {ny[CW-1:0], nx[CW-1:0]};
               tail_in = tail_ff + 1'b1;
            end
            dir_in = dir_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
      if (q_we) queue_mem[q_wa] <= q_wd;
      map_rd_ff  <= map_mem[rd_a];
      mark_rd_ff <= mark_mem[rd_a];
      q_rd_ff    <= queue_mem[head_ff[QAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      sx_ff <= sx_in; sy_ff <= sy_in; dx_ff <= dx_in; dy_ff <= dy_in;
      vent_ff <= vent_in; cx_ff <= cx_in; cy_ff <= cy_in;
      dir_ff <= dir_in; res_ff <= res_in;
   end

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= QCW'(QUEUE_DEPTH)) else $error("queue overflow");
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.ready |=> $stable(res_ff) && rsp_port.valid)
      else $error("result dropped");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> !req_port.ready) else $error("accept during result");

endmodule
